// ===== design/dual_fnv1a_name_hasher_assert.svh =====
// Assertion macros shared by the name hasher RTL.
// Depends on nothing; expects signals named clock and reset in scope.
`ifndef DUAL_FNV1A_NAME_HASHER_ASSERT_SVH
`define DUAL_FNV1A_NAME_HASHER_ASSERT_SVH

// same-cycle implication
`define DFNV_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DFNV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dfnv_pkg.sv =====
// Package for the dual FNV-1a name hasher: constants and the FNV-1a mix step.
// No dependencies.
`default_nettype none

package dfnv_pkg;

   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned HASH_W  = 64;
   localparam int unsigned COUNT_W = 10;

   localparam logic [HASH_W-1:0]  FNV_BASIS  = 64'hcbf2_9ce4_8422_2325;
   localparam logic [UNIT_W-1:0]  ASCII_TOP  = 16'h007f;
   localparam logic [UNIT_W-1:0]  COLON_UNIT = 16'h003a;
   localparam logic [COUNT_W-1:0] COUNT_TOP  = '1;
   localparam logic [COUNT_W-1:0] MAX_LENGTH = 10'd512;

   // result tdata: exact, base, valid, padded to whole bytes
   localparam int unsigned RSP_BITS = 2 * HASH_W + 1;
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // h ^= byte; h *= 0x100000001b3, done as shift-add (2^40 + 0x1b3)
   function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {{(HASH_W-8){1'b0}}, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

`default_nettype wire

// ===== design/dual_fnv1a_name_hasher.sv =====
// Dual FNV-1a 64 name hasher, top level.
// Depends on dfnv_pkg and dual_fnv1a_name_hasher_assert.svh.
//
// Takes a name as a stream of 16-bit code units on req_ (tlast on the final
// unit) and returns one item per name on rsp_: the FNV-1a 64 hash of the
// whole name, the FNV-1a 64 hash of the units before the first colon, and a
// valid flag. Only the low byte of each unit is hashed. A unit above 0x7f, or
// more than MAX_LENGTH units in a name, makes the name invalid and both
// hashes read zero. Units are taken one per cycle, back to back: each unit
// is held in an input register while combinational shift-add logic (the
// constant multiply by the FNV prime) updates the running hashes. A name's
// result is loaded into the result register from its last unit in the
// input register.
// The only stall is a last unit meeting a result register that is still
// full and not being drained.
`default_nettype none

module dual_fnv1a_name_hasher
   import dfnv_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // input channel
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [UNIT_W-1:0]  req_tdata,   // [15:0] code_unit
   input  wire logic               req_tlast,   // last unit of the name
   // result channel
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata    // [63:0] exact_hash, [127:64] base_hash,
                                                // [128] name_valid, rest zero
);

   // ---------------- input register ----------------
   logic              in_v_ff, in_v_in;
   logic [UNIT_W-1:0] unit_ff;
   logic              last_ff;
   logic              advance;

   // ---------------- per-name state ----------------
   logic [HASH_W-1:0]  whole_ff, whole_in;
   logic [HASH_W-1:0]  prefix_ff, prefix_in;
   logic               closed_ff, closed_in;
   logic               bad_ff, bad_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // ---------------- result register ----------------
   logic              rsp_v_ff, rsp_v_in;
   logic [HASH_W-1:0] exact_ff, base_ff;
   logic              ok_ff;

   // next-state values for the unit in the input register
   logic               is_colon;
   logic               bad_next;
   logic [HASH_W-1:0]  whole_next, prefix_next;
   logic               closed_next;
   logic [COUNT_W-1:0] count_next;

   // A non-last unit never waits; a last unit needs room in the result register.
   assign advance    = in_v_ff && (!last_ff || !rsp_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || advance;

   assign is_colon    = (unit_ff == COLON_UNIT);
   assign bad_next    = bad_ff || (unit_ff > ASCII_TOP) || (count_ff >= MAX_LENGTH);
   assign whole_next  = fnv_mix(whole_ff, unit_ff[7:0]);
   assign prefix_next = (closed_ff || is_colon) ? prefix_ff : fnv_mix(prefix_ff, unit_ff[7:0]);
   assign closed_next = closed_ff || is_colon;
   assign count_next  = (count_ff == COUNT_TOP) ? count_ff : count_ff + 1'b1;

   always_comb begin
      in_v_in   = in_v_ff;
      whole_in  = whole_ff;
      prefix_in = prefix_ff;
      closed_in = closed_ff;
      bad_in    = bad_ff;
      count_in  = count_ff;
      rsp_v_in  = rsp_v_ff && !rsp_tready;

      if (req_tvalid && req_tready) begin
         in_v_in = 1'b1;
      end else if (advance) begin
         in_v_in = 1'b0;
      end

      if (advance) begin
         if (last_ff) begin
            // name done: back to the start state
            whole_in  = FNV_BASIS;
            prefix_in = FNV_BASIS;
            closed_in = 1'b0;
            bad_in    = 1'b0;
            count_in  = '0;
            rsp_v_in  = 1'b1;
         end else begin
            whole_in  = whole_next;
            prefix_in = prefix_next;
            closed_in = closed_next;
            bad_in    = bad_next;
            count_in  = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
         whole_ff  <= FNV_BASIS;
         prefix_ff <= FNV_BASIS;
         closed_ff <= 1'b0;
         bad_ff    <= 1'b0;
         count_ff  <= '0;
      end else begin
         in_v_ff   <= in_v_in;
         rsp_v_ff  <= rsp_v_in;
         whole_ff  <= whole_in;
         prefix_ff <= prefix_in;
         closed_ff <= closed_in;
         bad_ff    <= bad_in;
         count_ff  <= count_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         unit_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (advance && last_ff) begin
         exact_ff <= bad_next ? '0 : whole_next;
         base_ff  <= bad_next ? '0 : prefix_next;
         ok_ff    <= !bad_next;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_BITS){1'b0}}, ok_ff, base_ff, exact_ff};

   // ---------------- assertions ----------------
`include "dual_fnv1a_name_hasher_assert.svh"

   `DFNV_ASSERT_NOW(a_invalid_zero, rsp_v_ff && !ok_ff, exact_ff == '0 && base_ff == '0, "invalid name with nonzero hash")
   `DFNV_ASSERT_NEXT(a_name_restart, advance && last_ff, count_ff == '0 && !closed_ff && !bad_ff && whole_ff == FNV_BASIS, "state not cleared after name")
   `DFNV_ASSERT_NEXT(a_in_hold, in_v_ff && !advance, in_v_ff && $stable(unit_ff) && $stable(last_ff), "input register lost a unit")
   `DFNV_ASSERT_NEXT(a_rsp_hold, rsp_v_ff && !rsp_tready, rsp_v_ff && $stable(exact_ff) && $stable(base_ff), "result register overwritten")

endmodule

`default_nettype wire

// ===== tb/dual_fnv1a_name_hasher_checker.sv =====
// Scoreboard for the dual FNV-1a name hasher: watches both item channels,
// predicts each name's result and compares it field by field. Uses dfnv_pkg.
`default_nettype none

module dual_fnv1a_name_hasher_checker
   import dfnv_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [UNIT_W-1:0] req_tdata,
   input  wire logic             req_tlast,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [RSP_W-1:0] rsp_tdata,
   output int unsigned           mismatch_count,
   output int unsigned           names_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

   typedef struct packed {
      logic [HASH_W-1:0] exact_hash;
      logic [HASH_W-1:0] base_hash;
      logic              name_valid;
   } name_digest_type;

   // running state of the name being received
   logic [HASH_W-1:0]  whole_acc;
   logic [HASH_W-1:0]  prefix_acc;
   logic               prefix_done;
   logic               bad_name;
   logic [COUNT_W-1:0] units_seen;

   name_digest_type digests_due[$];

   function automatic logic [HASH_W-1:0] fnv1a_byte(input logic [HASH_W-1:0] h,
                                                    input logic [7:0] b);
      return (h ^ {{(HASH_W-8){1'b0}}, b}) * FNV_PRIME;
   endfunction

   task automatic restart_name();
      whole_acc   = FNV_BASIS;
      prefix_acc  = FNV_BASIS;
      prefix_done = 1'b0;
      bad_name    = 1'b0;
      units_seen  = '0;
   endtask

   task automatic absorb_unit(input logic [UNIT_W-1:0] unit, input logic is_last);
      name_digest_type d;
      if (units_seen >= MAX_LENGTH) bad_name = 1'b1;
      if (unit > ASCII_TOP) bad_name = 1'b1;
      if (units_seen != COUNT_TOP) units_seen = units_seen + 1'b1;
      whole_acc = fnv1a_byte(whole_acc, unit[7:0]);
      // base hash stops at the first colon, colon excluded
      if (!prefix_done) begin
         if (unit == COLON_UNIT) prefix_done = 1'b1;
         else prefix_acc = fnv1a_byte(prefix_acc, unit[7:0]);
      end
      if (is_last) begin
         if (bad_name) d = '0;
         else d = '{exact_hash: whole_acc, base_hash: prefix_acc, name_valid: 1'b1};
         digests_due.push_back(d);
         restart_name();
      end
   endtask

   task automatic compare_digest(input logic [RSP_W-1:0] data);
      name_digest_type want;
      name_digest_type got;
      got.exact_hash = data[HASH_W-1:0];
      got.base_hash  = data[2*HASH_W-1:HASH_W];
      got.name_valid = data[2*HASH_W];
      if (digests_due.size() == 0) begin
         $error("unexpected result item: exact_hash %h base_hash %h name_valid %b",
                got.exact_hash, got.base_hash, got.name_valid);
         mismatch_count++;
         return;
      end
      want = digests_due.pop_front();
      if (got.exact_hash !== want.exact_hash) begin
         $error("exact_hash: expected %h, actual %h", want.exact_hash, got.exact_hash);
         mismatch_count++;
      end
      if (got.base_hash !== want.base_hash) begin
         $error("base_hash: expected %h, actual %h", want.base_hash, got.base_hash);
         mismatch_count++;
      end
      if (got.name_valid !== want.name_valid) begin
         $error("name_valid: expected %b, actual %b", want.name_valid, got.name_valid);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_name();
         digests_due.delete();
         mismatch_count = 0;
         names_in_flight <= 0;
      end else begin
         // results first: an item out with nothing queued must not match a new name
         if (rsp_tvalid && rsp_tready) compare_digest(rsp_tdata);
         if (req_tvalid && req_tready) absorb_unit(req_tdata, req_tlast);
         names_in_flight <= digests_due.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/dual_fnv1a_name_hasher_tb.sv =====
// Testbench top for the dual FNV-1a name hasher: clock, reset, name stimulus,
// result backpressure and the verdict. Uses dfnv_pkg and the checker module.
`default_nettype none

module dual_fnv1a_name_hasher_tb
   import dfnv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RUN_LIMIT    = 400000; // cycles before we call it hung
   localparam int unsigned RANDOM_UNITS = 240;    // units in the random part
   localparam int unsigned DRAIN_CYCLES = 32;     // idle wait after all results are back

   typedef logic [UNIT_W-1:0] unit_list_type[$];

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [UNIT_W-1:0]  req_tdata = '0;   // [15:0] code_unit
   logic               req_tlast = 1'b0; // last unit of the name
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;        // [63:0] exact_hash, [127:64] base_hash,
                                         // [128] name_valid

   int unsigned        mismatch_count;
   int unsigned        names_in_flight;
   int unsigned        cycle_count = 0;
   int unsigned        units_sent = 0;
   int unsigned        send_idle_pct = 0;  // chance per item of a sender gap
   int unsigned        recv_stall_pct = 0; // chance per cycle of rsp_tready low

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dual_fnv1a_name_hasher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dual_fnv1a_name_hasher_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .names_in_flight (names_in_flight)
   );

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One unit per call. tvalid stays high between back-to-back units; it is
   // only dropped when a gap is drawn, so it never toggles within one step.
   task automatic send_unit(input logic [UNIT_W-1:0] unit, input logic is_last);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      units_sent++;
   endtask

   task automatic send_name(input unit_list_type units);
      foreach (units[i]) send_unit(units[i], i == units.size() - 1);
   endtask

   task automatic send_text(input string s);
      unit_list_type units;
      for (int i = 0; i < s.len(); i++) units.push_back({8'h00, s[i]});
      send_name(units);
   endtask

   // plain lowercase name of a given length, one colon at colon_at (<0: none)
   function automatic unit_list_type plain_name(input int len, input int colon_at);
      unit_list_type units;
      for (int i = 0; i < len; i++)
         units.push_back(i == colon_at ? COLON_UNIT : UNIT_W'($urandom_range(8'h61, 8'h7a)));
      return units;
   endfunction

   // sender holds off until every result so far has come back
   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (names_in_flight != 0);
   endtask

   // Random name: short ASCII names with colons sprinkled in, some broken
   // by a non-ASCII unit.
   task automatic send_random_name();
      unit_list_type units;
      int len;
      int pick;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) units.push_back(COLON_UNIT);
         else if (pick < 75) units.push_back(UNIT_W'($urandom_range(8'h20, 8'h7e)));
         else units.push_back(UNIT_W'($urandom_range(0, ASCII_TOP)));
      end
      // broken name: one unit anywhere above the ASCII range
      if ($urandom_range(99) < 12)
         units[$urandom_range(0, len - 1)] = UNIT_W'($urandom_range(ASCII_TOP + 1, 16'hffff));
      send_name(units);
   endtask

   initial begin
      unit_list_type units;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed names ----
      send_text("a");                       // single unit
      send_text(":");                       // colon only: base hash is the basis
      send_text(":ab");                     // colon first
      send_text("ns:key:x");                // second colon goes only into exact
      units = '{16'h0000, ASCII_TOP};       // lowest and highest ASCII units
      send_name(units);
      units = '{16'h0041, 16'h0080};        // just above ASCII
      send_name(units);
      units = '{16'hffff};                  // max unit, alone
      send_name(units);
      units = '{16'h0062, 16'h013a, 16'h0063}; // colon low byte, high byte set
      send_name(units);
      send_text("ok:1");                    // state must be clean after invalid

      // length limit: exactly MAX_LENGTH, then one over
      send_name(plain_name(MAX_LENGTH, 100));
      send_name(plain_name(MAX_LENGTH + 1, -1));
      send_text("z");

      hold_until_drained();

      // ---- random names, four backpressure phases ----
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         units_sent = 0;
         while (units_sent < RANDOM_UNITS / 4) send_random_name();
         // mid-run pause with results still queued behind stalls
         if (phase == 2) hold_until_drained();
      end

      req_tvalid <= 1'b0;
      recv_stall_pct = 0;
      do @(posedge clock); while (names_in_flight != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== dual_fnv1a_name_hasher.f =====
+incdir+design
design/dfnv_pkg.sv
design/dual_fnv1a_name_hasher.sv
tb/dual_fnv1a_name_hasher_checker.sv
tb/dual_fnv1a_name_hasher_tb.sv
